// ===== hdl/pderm_pkg.sv =====
`default_nettype none

package pderm_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 8;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int FIGURE_W  = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 16;

  // Rate is count * 1000 / elapsed; the scaled count fits in this many bits.
  localparam int RATE_SCALE   = 1000;
  localparam int SCALE_W      = 10;
  localparam int NUMERATOR_W  = COUNT_W + SCALE_W;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd50;
  localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ATTACH = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_DETACH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SLOT   = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic find;
    logic exec;
    logic close;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic needs_div;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/pderm_div.sv =====
`default_nettype none

module pderm_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numerator,
  input  wire logic [DEN_W-1:0] denominator,
  output logic      [NUM_W-1:0] quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step per cycle, most significant numerator bit first.
  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      rem      <= '0;
      den      <= denominator;
      num      <= numerator;
      quotient <= '0;
      cnt      <= CNT_W'(NUM_W);
    end else if (busy) begin
      rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
      num      <= {num[NUM_W-2:0], 1'b0};
      cnt      <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pderm_dp.sv =====
`default_nettype none

module pderm_dp #(
  parameter int SLOTS = pderm_pkg::SLOTS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pderm_pkg::ctrl_cmd_t               cmd,
  output pderm_pkg::dp_stat_t                     stat,
  input  wire logic [pderm_pkg::CMD_W-1:0]        command,
  input  wire logic [pderm_pkg::ADDR_W-1:0]       device_address,
  input  wire logic [pderm_pkg::TIME_W-1:0]       timestamp_ms,
  input  wire logic                               cfg_write,
  input  wire logic [pderm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pderm_pkg::CFG_W-1:0]        cfg_data,
  output logic      [pderm_pkg::STATUS_W-1:0]     status,
  output logic      [pderm_pkg::FIGURE_W-1:0]     rate_hz,
  output logic      [pderm_pkg::FIGURE_W-1:0]     peak_hz,
  output logic      [pderm_pkg::FIGURE_W-1:0]     total_events,
  output logic                                    spammy,
  output logic                                    window_closed,
  output logic                                    alert
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW    = pderm_pkg::FIGURE_W;
  localparam int NW    = pderm_pkg::NUMERATOR_W;

  // Configuration.
  logic [pderm_pkg::CFG_W-1:0] threshold;
  logic [pderm_pkg::CFG_W-1:0] window_len;

  // Slot table.
  logic [SLOTS-1:0]                in_use;
  logic [pderm_pkg::ADDR_W-1:0]    slot_addr  [SLOTS];
  logic [pderm_pkg::TIME_W-1:0]    win_start  [SLOTS];
  logic [pderm_pkg::COUNT_W-1:0]   win_count  [SLOTS];
  logic [FW-1:0]                   cur_rate   [SLOTS];
  logic [FW-1:0]                   peak       [SLOTS];
  logic [FW-1:0]                   ev_total   [SLOTS];

  // Item being worked on.
  pderm_pkg::cmd_t                 item_cmd;
  logic [pderm_pkg::ADDR_W-1:0]    item_addr;
  logic [pderm_pkg::TIME_W-1:0]    item_now;
  logic [IDX_W-1:0]                idx;
  logic                            hit;

  // Result waiting for the output register.
  pderm_pkg::status_t              pend_status;
  logic [FW-1:0]                   pend_rate;
  logic [FW-1:0]                   pend_peak;
  logic [FW-1:0]                   pend_total;
  logic                            pend_spammy;
  logic                            pend_closed;
  logic                            pend_alert;

  // Lowest matching slot and lowest free slot.
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] free_idx;
  logic             any_match;
  logic             any_free;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    any_match = 1'b0;
    any_free  = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (in_use[i] && slot_addr[i] == item_addr) begin
        match_idx = IDX_W'(i);
        any_match = 1'b1;
      end
      if (!in_use[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // Report arithmetic on the selected slot.
  logic [pderm_pkg::CFG_W-1:0]   wl;
  logic [pderm_pkg::TIME_W-1:0]  elapsed;
  logic [pderm_pkg::COUNT_W-1:0] new_count;
  logic [FW-1:0]                 new_total;
  logic [NW-1:0]                 scaled;
  logic [NW-1:0]                 quotient;
  logic [FW-1:0]                 q_rate;
  logic                          q_above;
  logic                          div_start;
  logic                          needs_div;
  logic                          div_done;

  assign wl        = (window_len == '0) ? pderm_pkg::CFG_W'(1) : window_len;
  assign elapsed   = item_now - win_start[idx];
  assign new_count = (win_count[idx] == '1) ? win_count[idx] : win_count[idx] + 1'b1;
  assign new_total = ev_total[idx] + 1'b1;
  assign scaled    = NW'(new_count) * NW'(pderm_pkg::RATE_SCALE);
  assign q_rate    = FW'(quotient);
  assign q_above   = q_rate > FW'(threshold);

  assign needs_div = hit && item_cmd == pderm_pkg::CMD_REPORT
                     && elapsed >= pderm_pkg::TIME_W'(wl);
  assign div_start = cmd.exec && needs_div;
  assign stat      = {needs_div, div_done};

  pderm_div #(
    .NUM_W (NW),
    .DEN_W (pderm_pkg::TIME_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (scaled),
    .denominator (elapsed),
    .quotient    (quotient),
    .done        (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= pderm_pkg::THRESHOLD_RESET;
      window_len <= pderm_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      if (cfg_index == pderm_pkg::CFG_THRESHOLD) begin
        threshold <= cfg_data;
      end
      if (cfg_index == pderm_pkg::CFG_WINDOW) begin
        window_len <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= pderm_pkg::cmd_t'(command);
      item_addr <= device_address;
      item_now  <= timestamp_ms;
    end
    if (cmd.find) begin
      if (item_cmd == pderm_pkg::CMD_ATTACH) begin
        idx <= free_idx;
        hit <= any_free;
      end else begin
        idx <= match_idx;
        hit <= any_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (cmd.exec) begin
      pend_closed <= 1'b0;
      pend_alert  <= 1'b0;
      pend_status <= pderm_pkg::ST_OK;
      pend_rate   <= cur_rate[idx];
      pend_peak   <= peak[idx];
      pend_total  <= ev_total[idx];
      pend_spammy <= cur_rate[idx] > FW'(threshold);
      if (!hit) begin
        pend_status <= (item_cmd == pderm_pkg::CMD_ATTACH) ? pderm_pkg::ST_NO_SLOT
                                                          : pderm_pkg::ST_NOT_FOUND;
        pend_rate   <= '0;
        pend_peak   <= '0;
        pend_total  <= '0;
        pend_spammy <= 1'b0;
      end else begin
        unique case (item_cmd)
          pderm_pkg::CMD_ATTACH: begin
            in_use[idx]    <= 1'b1;
            slot_addr[idx] <= item_addr;
            win_start[idx] <= item_now;
            win_count[idx] <= '0;
            cur_rate[idx]  <= '0;
            peak[idx]      <= '0;
            ev_total[idx]  <= '0;
            pend_rate      <= '0;
            pend_peak      <= '0;
            pend_total     <= '0;
            pend_spammy    <= 1'b0;
          end
          pderm_pkg::CMD_REPORT: begin
            ev_total[idx] <= new_total;
            pend_total    <= new_total;
            if (needs_div) begin
              win_count[idx] <= '0;
              win_start[idx] <= item_now;
            end else begin
              win_count[idx] <= new_count;
            end
          end
          pderm_pkg::CMD_DETACH: begin
            in_use[idx] <= 1'b0;
          end
          pderm_pkg::CMD_READ: begin
          end
        endcase
      end
    end else if (cmd.close) begin
      // The divider has the new rate: store it and finish the result.
      cur_rate[idx] <= q_rate;
      if (q_rate > peak[idx]) begin
        peak[idx] <= q_rate;
        pend_peak <= q_rate;
      end else begin
        pend_peak <= peak[idx];
      end
      pend_rate   <= q_rate;
      pend_spammy <= q_above;
      pend_alert  <= q_above;
      pend_closed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= pend_status;
      rate_hz       <= pend_rate;
      peak_hz       <= pend_peak;
      total_events  <= pend_total;
      spammy        <= pend_spammy;
      window_closed <= pend_closed;
      alert         <= pend_alert;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pderm_ctrl.sv =====
`default_nettype none

module pderm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pderm_pkg::ctrl_cmd_t      cmd,
  input  wire pderm_pkg::dp_stat_t  stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.needs_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.close = stat.div_done;
        if (stat.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/per_device_event_rate_monitor.sv =====
// Each item passes through capture, slot lookup and execution before the output
// register takes its result; a window-closing report also waits out a 26-step
// restoring divider pass. The next item is taken in only once the result is handed off.
// Reset (rst, synchronous, active high) frees every slot, empties the output register
// and loads the threshold with 50 Hz and the window length with 1000 ms.
`default_nettype none

module per_device_event_rate_monitor #(
  parameter int SLOTS = pderm_pkg::SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input item channel.
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [pderm_pkg::CMD_W-1:0]      command,
  input  wire logic [pderm_pkg::ADDR_W-1:0]     device_address,
  input  wire logic [pderm_pkg::TIME_W-1:0]     timestamp_ms,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [pderm_pkg::STATUS_W-1:0]   status,
  output logic      [pderm_pkg::FIGURE_W-1:0]   rate_hz,
  output logic      [pderm_pkg::FIGURE_W-1:0]   peak_hz,
  output logic      [pderm_pkg::FIGURE_W-1:0]   total_events,
  output logic                                  spammy,
  output logic                                  window_closed,
  output logic                                  alert,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pderm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pderm_pkg::CFG_W-1:0]      cfg_data
);

  // The controller walks each item through capture, slot lookup, execution,
  // an optional divide and the hand-off to the output register. The output
  // register holds a finished result while the next beat is already taken in.
  // Configuration writes are taken in every cycle; index 0 is the threshold and
  // index 1 the window length. Other fields of the slot table are not reset:
  // an attach writes every field of the slot it takes.

  pderm_pkg::ctrl_cmd_t cmd;
  pderm_pkg::dp_stat_t  stat;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  pderm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pderm_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .command        (command),
    .device_address (device_address),
    .timestamp_ms   (timestamp_ms),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .status         (status),
    .rate_hz        (rate_hz),
    .peak_hz        (peak_hz),
    .total_events   (total_events),
    .spammy         (spammy),
    .window_closed  (window_closed),
    .alert          (alert)
  );

  // One item at a time: an accepted beat closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A failed command carries no figures.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pderm_pkg::ST_OK |->
      rate_hz == '0 && peak_hz == '0 && total_events == '0 && !spammy
      && !window_closed && !alert)
    else $error("failed command returned figures");

  // An alert only comes from a window that just closed above the threshold.
  a_alert_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert |-> window_closed && spammy && peak_hz >= rate_hz)
    else $error("alert without a closed window above threshold");

  // The peak never trails the stored rate.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_hz >= rate_hz)
    else $error("peak rate below current rate");

endmodule

`default_nettype wire

// ===== tb/sv/per_device_event_rate_monitor_test.sv =====
`default_nettype none

// Self-checking bench for the per-device event rate monitor.
//
// Every accepted input beat runs through a cycle-free model of the slot table
// kept in this module. The model's answer is queued, and each result beat
// leaving the block is compared field by field with the oldest queued answer.
// A few directed rows carry a hand-written answer instead, because they can be
// read straight off the command: misses, attaches that find a slot and attaches on a full table.
module per_device_event_rate_monitor_test;

  localparam int SLOT_COUNT = pderm_pkg::SLOTS_DEFAULT;

  // The limit is in time units and lies above the slowest correct run, with every
  // item waiting out the longest input gap, a window close and the longest output
  // stall.
  localparam int RUN_LIMIT = 10_000_000;

  // Margin after the last result.
  localparam int TAIL_CYCLES = 40;

  // One result beat, in port order.
  typedef struct packed {
    pderm_pkg::status_t             status;
    logic [pderm_pkg::FIGURE_W-1:0] rate;
    logic [pderm_pkg::FIGURE_W-1:0] peak;
    logic [pderm_pkg::FIGURE_W-1:0] total;
    logic                           spammy;
    logic                           closed;
    logic                           alert;
  } verdict_t;

  // One row of the directed table: either a register write or an input beat.
  // Rows with a typed answer bypass the model's answer but still update it.
  typedef struct {
    bit                              is_reg;
    logic [pderm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [pderm_pkg::CFG_W-1:0]     reg_val;
    pderm_pkg::cmd_t                 op;
    logic [pderm_pkg::ADDR_W-1:0]    addr;
    logic [pderm_pkg::TIME_W-1:0]    stamp;
    bit                              typed;
    verdict_t                        answer;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [pderm_pkg::CMD_W-1:0]       command = '0;
  logic [pderm_pkg::ADDR_W-1:0]      device_address = '0;
  logic [pderm_pkg::TIME_W-1:0]      timestamp_ms = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [pderm_pkg::STATUS_W-1:0]    status;
  logic [pderm_pkg::FIGURE_W-1:0]    rate_hz;
  logic [pderm_pkg::FIGURE_W-1:0]    peak_hz;
  logic [pderm_pkg::FIGURE_W-1:0]    total_events;
  logic                              spammy;
  logic                              window_closed;
  logic                              alert;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [pderm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pderm_pkg::CFG_W-1:0]       cfg_data = '0;

  per_device_event_rate_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .device_address (device_address),
    .timestamp_ms   (timestamp_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .rate_hz        (rate_hz),
    .peak_hz        (peak_hz),
    .total_events   (total_events),
    .spammy         (spammy),
    .window_closed  (window_closed),
    .alert          (alert),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the slot table and of the two registers.
  logic                           slot_busy   [SLOT_COUNT];
  logic [pderm_pkg::ADDR_W-1:0]   slot_addr   [SLOT_COUNT];
  logic [pderm_pkg::TIME_W-1:0]   win_start   [SLOT_COUNT];
  logic [pderm_pkg::COUNT_W-1:0]  win_count   [SLOT_COUNT];
  logic [pderm_pkg::FIGURE_W-1:0] last_rate   [SLOT_COUNT];
  logic [pderm_pkg::FIGURE_W-1:0] best_rate   [SLOT_COUNT];
  logic [pderm_pkg::FIGURE_W-1:0] events_seen [SLOT_COUNT];
  logic [pderm_pkg::CFG_W-1:0]    thr_hz     = pderm_pkg::THRESHOLD_RESET;
  logic [pderm_pkg::CFG_W-1:0]    win_len_ms = pderm_pkg::WINDOW_RESET;

  verdict_t  outstanding[$];
  stim_row_t directed[$];

  int  mismatches = 0;
  int  beats_checked = 0;
  int  items_sent = 0;
  int  windows_shut = 0;
  int  alerts_seen = 0;
  int  misses_seen = 0;
  int  full_table_seen = 0;
  bit  calm_in = 1'b0;
  bit  calm_out = 1'b0;
  int  hold_left = 0;
  logic [pderm_pkg::TIME_W-1:0] now_ms = '0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i] = 1'b0;
      slot_addr[i] = '0;
      win_start[i] = '0;
      win_count[i] = '0;
      last_rate[i] = '0;
      best_rate[i] = '0;
      events_seen[i] = '0;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic void free_slot(int s);
    slot_busy[s] = 1'b0;
    slot_addr[s] = '0;
    win_start[s] = '0;
    win_count[s] = '0;
    last_rate[s] = '0;
    best_rate[s] = '0;
    events_seen[s] = '0;
  endfunction

  // Applies one command to the shadow table and returns the result beat it
  // should produce.
  function automatic verdict_t predict_outcome(pderm_pkg::cmd_t op,
                                               logic [pderm_pkg::ADDR_W-1:0] addr,
                                               logic [pderm_pkg::TIME_W-1:0] now);
    verdict_t r;
    int s;
    int i;
    logic [pderm_pkg::TIME_W-1:0] span;
    logic [pderm_pkg::TIME_W-1:0] elapsed;
    r = '0;
    s = -1;
    if (op == pderm_pkg::CMD_ATTACH) begin
      for (i = SLOT_COUNT - 1; i >= 0; i--) if (!slot_busy[i]) s = i;
      if (s < 0) begin
        r.status = pderm_pkg::ST_NO_SLOT;
      end else begin
        free_slot(s);
        slot_busy[s] = 1'b1;
        slot_addr[s] = addr;
        win_start[s] = now;
      end
      return r;
    end
    // Every other command acts on the lowest slot holding this address.
    for (i = SLOT_COUNT - 1; i >= 0; i--) if (slot_busy[i] && slot_addr[i] == addr) s = i;
    if (s < 0) begin
      r.status = pderm_pkg::ST_NOT_FOUND;
      return r;
    end
    if (op == pderm_pkg::CMD_REPORT) begin
      // A zero window length behaves as one millisecond.
      span = (win_len_ms == '0) ? 32'd1 : 32'(win_len_ms);
      events_seen[s] = events_seen[s] + 32'd1;
      if (win_count[s] != '1) win_count[s] = win_count[s] + 1'b1;
      elapsed = now - win_start[s];
      if (elapsed >= span) begin
        last_rate[s] = (32'(win_count[s]) * 32'(pderm_pkg::RATE_SCALE)) / elapsed;
        if (last_rate[s] > best_rate[s]) best_rate[s] = last_rate[s];
        win_start[s] = now;
        win_count[s] = '0;
        r.closed = 1'b1;
        r.alert = (last_rate[s] > 32'(thr_hz));
      end
    end
    r.rate = last_rate[s];
    r.peak = best_rate[s];
    r.total = events_seen[s];
    r.spammy = (last_rate[s] > 32'(thr_hz));
    if (op == pderm_pkg::CMD_DETACH) free_slot(s);
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int stall_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // Offers one beat on the input channel and queues its expected result at the
  // edge that accepts it. The caller decides what valid does afterwards, so a
  // back-to-back beat never sees valid dropped and raised in the same step.
  task automatic offer_item(input pderm_pkg::cmd_t op,
                            input logic [pderm_pkg::ADDR_W-1:0] addr,
                            input logic [pderm_pkg::TIME_W-1:0] stamp, input bit typed,
                            input verdict_t answer);
    int gap;
    verdict_t want;
    gap = (calm_in || $urandom_range(0, 1) == 0) ? 0 : stall_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= op;
    device_address <= addr;
    timestamp_ms   <= stamp;
    do @(posedge clk); while (!in_ready);
    want = predict_outcome(op, addr, stamp);
    if (typed) want = answer;
    outstanding.push_back(want);
    items_sent++;
    if (want.closed) windows_shut++;
    if (want.alert) alerts_seen++;
    if (want.status == pderm_pkg::ST_NOT_FOUND) misses_seen++;
    if (want.status == pderm_pkg::ST_NO_SLOT) full_table_seen++;
  endtask

  // Holds the input channel quiet until every queued result has come back.
  // At least one edge passes, so valid is never driven twice in one step.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding.size() != 0) @(posedge clk);
  endtask

  // Register writes are only issued with the block drained.
  task automatic write_register(input logic [pderm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pderm_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pderm_pkg::CFG_THRESHOLD: thr_hz = val;
      pderm_pkg::CFG_WINDOW:    win_len_ms = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic stim_row_t row_cmd(pderm_pkg::cmd_t op,
                                        logic [pderm_pkg::ADDR_W-1:0] addr,
                                        logic [pderm_pkg::TIME_W-1:0] stamp);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.op = op;
    r.addr = addr;
    r.stamp = stamp;
    r.typed = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  // A row whose answer is the given status with every figure zero.
  function automatic stim_row_t row_fixed(pderm_pkg::cmd_t op,
                                          logic [pderm_pkg::ADDR_W-1:0] addr,
                                          logic [pderm_pkg::TIME_W-1:0] stamp,
                                          pderm_pkg::status_t st);
    stim_row_t r;
    r = row_cmd(op, addr, stamp);
    r.typed = 1'b1;
    r.answer.status = st;
    return r;
  endfunction

  function automatic stim_row_t row_reg(logic [pderm_pkg::CFG_IDX_W-1:0] idx,
                                        logic [pderm_pkg::CFG_W-1:0] val);
    stim_row_t r;
    r = row_cmd(pderm_pkg::CMD_READ, '0, '0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Result side: random back-pressure, suspended while calm_out is set.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm_out && $urandom_range(0, 7) == 0) hold_left <= stall_length();
    end
  end

  // Result checker: compares each accepted result beat with the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (outstanding.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d arrived with nothing outstanding",
                                beats_checked));
      end else begin
        want = outstanding.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                  beats_checked, status, want.status));
        if (rate_hz !== want.rate)
          flag_mismatch($sformatf("beat %0d rate_hz %0d, expected %0d",
                                  beats_checked, rate_hz, want.rate));
        if (peak_hz !== want.peak)
          flag_mismatch($sformatf("beat %0d peak_hz %0d, expected %0d",
                                  beats_checked, peak_hz, want.peak));
        if (total_events !== want.total)
          flag_mismatch($sformatf("beat %0d total_events %0d, expected %0d",
                                  beats_checked, total_events, want.total));
        if (spammy !== want.spammy)
          flag_mismatch($sformatf("beat %0d spammy %b, expected %b",
                                  beats_checked, spammy, want.spammy));
        if (window_closed !== want.closed)
          flag_mismatch($sformatf("beat %0d window_closed %b, expected %b",
                                  beats_checked, window_closed, want.closed));
        if (alert !== want.alert)
          flag_mismatch($sformatf("beat %0d alert %b, expected %b",
                                  beats_checked, alert, want.alert));
      end
    end
  end

  // Main sequence.
  initial begin
    logic [pderm_pkg::CFG_W-1:0]  thr_list [5];
    logic [pderm_pkg::CFG_W-1:0]  win_list [5];
    logic [pderm_pkg::ADDR_W-1:0] pool [6];
    logic [pderm_pkg::ADDR_W-1:0] addr;
    logic [pderm_pkg::TIME_W-1:0] stamp;
    logic [pderm_pkg::TIME_W-1:0] span;
    pderm_pkg::cmd_t op;
    int pick;
    int step;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. With an empty table every lookup misses; then the table
    // is filled, including a second slot for the same address, and one more
    // attach finds no room. The reports that follow cover a short window, a
    // window spanning the timestamp wrap, the largest possible elapsed time
    // and commands on a duplicated address, which must hit the lower slot.
    directed.push_back(row_fixed(pderm_pkg::CMD_READ, 8'h00, 32'd0, pderm_pkg::ST_NOT_FOUND));
    directed.push_back(row_fixed(pderm_pkg::CMD_REPORT, 8'hFF, 32'd0,
                                 pderm_pkg::ST_NOT_FOUND));
    directed.push_back(row_fixed(pderm_pkg::CMD_DETACH, 8'h12, 32'd0,
                                 pderm_pkg::ST_NOT_FOUND));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h00, 32'd0, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'hFF, 32'hFFFF_FF00,
                                 pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h55, 32'd1, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'hAA, 32'd100, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h12, 32'd100, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h12, 32'd200, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h80, 32'd0, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h01, 32'd0, pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h33, 32'd50,
                                 pderm_pkg::ST_NO_SLOT));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'h00, 32'd5));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'h00, 32'd1000));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'hFF, 32'h0000_0300));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'h55, 32'd0));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'h12, 32'd1100));
    directed.push_back(row_cmd(pderm_pkg::CMD_READ,   8'h12, 32'd1100));
    directed.push_back(row_cmd(pderm_pkg::CMD_DETACH, 8'h12, 32'd1100));
    directed.push_back(row_cmd(pderm_pkg::CMD_READ,   8'h12, 32'd1100));
    // Zero threshold and a one-millisecond window: the next report closes a
    // window at the highest rate a single event can give and must alert.
    directed.push_back(row_reg(pderm_pkg::CFG_THRESHOLD, 16'd0));
    directed.push_back(row_reg(pderm_pkg::CFG_WINDOW, 16'd1));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'hAA, 32'd101));
    directed.push_back(row_cmd(pderm_pkg::CMD_REPORT, 8'hAA, 32'd101));
    directed.push_back(row_reg(pderm_pkg::CFG_THRESHOLD, 16'hFFFF));
    directed.push_back(row_reg(pderm_pkg::CFG_WINDOW, 16'hFFFF));
    directed.push_back(row_cmd(pderm_pkg::CMD_READ,   8'hAA, 32'hFFFF_FFFF));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h33, 32'hFFFF_FFFF,
                                 pderm_pkg::ST_OK));
    directed.push_back(row_fixed(pderm_pkg::CMD_ATTACH, 8'h44, 32'hFFFF_FFFF,
                                 pderm_pkg::ST_NO_SLOT));
    directed.push_back(row_cmd(pderm_pkg::CMD_DETACH, 8'hAA, 32'hFFFF_FFFF));

    foreach (directed[k]) begin
      if (directed[k].is_reg) begin
        settle_outputs();
        write_register(directed[k].reg_idx, directed[k].reg_val);
      end else begin
        offer_item(directed[k].op, directed[k].addr, directed[k].stamp,
                   directed[k].typed, directed[k].answer);
      end
    end

    // Random phases, each under its own register setting. Most beats are
    // well-formed traffic on a small pool of addresses so that slots stay
    // attached long enough to close windows; the rest is noise with random
    // fields. Time usually creeps forward in steps scaled to the window and
    // now and then jumps far, which also walks it across the wrap.
    thr_list = '{16'd0, 16'hFFFF, 16'd50, 16'($urandom_range(0, 400)), 16'd30};
    win_list = '{16'd1, 16'hFFFF, 16'd1000, 16'($urandom_range(8, 64)), 16'd0};
    for (int ph = 0; ph < 5; ph++) begin
      settle_outputs();
      write_register(pderm_pkg::CFG_THRESHOLD, thr_list[ph]);
      write_register(pderm_pkg::CFG_WINDOW, win_list[ph]);
      calm_in = (ph == 2);
      calm_out = (ph == 3);
      pool[0] = 8'h00;
      pool[1] = 8'hFF;
      for (int p = 2; p < 6; p++) pool[p] = 8'($urandom_range(0, 255));
      span = (win_len_ms == '0) ? 32'd1 : 32'(win_len_ms);
      for (int n = 0; n < 205; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) step = $urandom_range(0, span / 16 + 2);
        else if (pick < 92) step = $urandom_range(0, span * 2);
        else if (pick < 98) step = span;
        else step = $urandom;
        now_ms = now_ms + 32'(step);
        addr = pool[$urandom_range(0, 5)];
        stamp = now_ms;
        pick = $urandom_range(0, 99);
        if (pick < 55) op = pderm_pkg::CMD_REPORT;
        else if (pick < 67) op = pderm_pkg::CMD_ATTACH;
        else if (pick < 75) op = pderm_pkg::CMD_DETACH;
        else if (pick < 87) op = pderm_pkg::CMD_READ;
        else begin
          op = pderm_pkg::cmd_t'($urandom_range(0, 3));
          addr = 8'($urandom_range(0, 255));
          stamp = $urandom;
        end
        offer_item(op, addr, stamp, 1'b0, '0);
        // Occasionally let the block run completely dry mid-phase.
        if ($urandom_range(0, 149) == 0) settle_outputs();
      end
    end

    settle_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", outstanding.size()));

    $display("Sent %0d beats and checked %0d results under the reset values and %s",
             items_sent, beats_checked, "seven written register settings.");
    $display("Seen: %0d window closes, %0d alerts, %0d misses, %0d attaches on a full table.",
             windows_shut, alerts_seen, misses_seen, full_table_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #RUN_LIMIT;
    $display("Timed out with %0d results outstanding.", outstanding.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pderm_pkg.sv
hdl/pderm_div.sv
hdl/pderm_dp.sv
hdl/pderm_ctrl.sv
hdl/per_device_event_rate_monitor.sv
tb/sv/per_device_event_rate_monitor_test.sv
